// ===== sv/tcce_pkg.sv =====
// tcce_pkg: shared types, constants and helpers for the text console cursor engine.
// Depends on nothing; used by tcce_ctrl, tcce_dp and text_console_cursor_engine_top.
`default_nettype none

package tcce_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = ROWS * COLS;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = $clog2(CELLS);

  // Fixed widths of the payload ports
  localparam int FUNC_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int RROW_W    = 5;
  localparam int RCOL_W    = 7;
  localparam int OROW_W    = 5;
  localparam int OCOL_W    = 7;
  localparam int OLIN_W    = 11;
  localparam int CELL_W    = ATTR_W + CHAR_W;

  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_BACK  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic scroll_step;
    logic fill_step;
    logic fill_reset;
    logic cnt_zero;
    logic cnt_row;
    logic cnt_inc;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  exec_scroll;
    logic  cnt_copy_end;
    logic  cnt_end;
  } sts_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ADDR_W-1:0] r,
                                                  input logic [ADDR_W-1:0] c);
    return r * ADDR_W'(COLS) + c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tcce_ctrl.sv =====
// tcce_ctrl: sequencer for the text console engine (init sweep, command, scroll, fill).
// Depends on tcce_pkg; drives the tcce_dp datapath through cmd_t.
`default_nettype none

module tcce_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire tcce_pkg::sts_t sts,
  output tcce_pkg::cmd_t     cmd
);

  tcce_pkg::state_t state;
  tcce_pkg::state_t state_next;
  logic             result_free;

  assign result_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcce_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Hold a result until it is taken; a new one replaces it only when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      tcce_pkg::ST_INIT: begin
        cmd.fill_step  = 1'b1;
        cmd.fill_reset = 1'b1;
        if (sts.cnt_end) begin
          state_next = tcce_pkg::ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      tcce_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = tcce_pkg::ST_EXEC;
        end
      end
      tcce_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.func == tcce_pkg::FUNC_CLEAR) begin
          cmd.cnt_zero = 1'b1;
          state_next   = tcce_pkg::ST_FILL;
        end else if (sts.func == tcce_pkg::FUNC_PUT && sts.exec_scroll) begin
          cmd.cnt_zero = 1'b1;
          state_next   = tcce_pkg::ST_SCROLL;
        end else begin
          state_next = tcce_pkg::ST_FINISH;
        end
      end
      tcce_pkg::ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (sts.cnt_copy_end) begin
          cmd.cnt_row = 1'b1;
          state_next  = tcce_pkg::ST_FILL;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      tcce_pkg::ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.cnt_end) begin
          state_next = tcce_pkg::ST_FINISH;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      tcce_pkg::ST_FINISH: begin
        if (result_free) begin
          cmd.load_result = 1'b1;
          state_next      = tcce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcce_pkg::ST_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/tcce_dp.sv =====
// tcce_dp: cell store, cursor, attribute register, sweep counter and result registers.
// Depends on tcce_pkg; commanded by tcce_ctrl.
`default_nettype none

module tcce_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tcce_pkg::cmd_t                cmd,
  output tcce_pkg::sts_t                     sts,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tcce_pkg::ATTR_W-1:0]   cfg_wr_data,
  input  wire logic [tcce_pkg::FUNC_W-1:0]   func,
  input  wire logic [tcce_pkg::CHAR_W-1:0]   char_code,
  input  wire logic [tcce_pkg::RROW_W-1:0]   read_row,
  input  wire logic [tcce_pkg::RCOL_W-1:0]   read_col,
  output logic [tcce_pkg::OROW_W-1:0]        cursor_row_out,
  output logic [tcce_pkg::OCOL_W-1:0]        cursor_col_out,
  output logic [tcce_pkg::OLIN_W-1:0]        cursor_linear,
  output logic [tcce_pkg::CHAR_W-1:0]        cell_char,
  output logic [tcce_pkg::ATTR_W-1:0]        cell_attr
);

  localparam int ROW_W  = tcce_pkg::ROW_W;
  localparam int COL_W  = tcce_pkg::COL_W;
  localparam int ADDR_W = tcce_pkg::ADDR_W;
  localparam int CELL_W = tcce_pkg::CELL_W;

  logic [CELL_W-1:0] mem [tcce_pkg::CELLS];

  logic [tcce_pkg::ATTR_W-1:0] attr;
  tcce_pkg::func_t             f_q;
  logic [tcce_pkg::CHAR_W-1:0] ch_q;
  logic [tcce_pkg::RROW_W-1:0] rr_q;
  logic [tcce_pkg::RCOL_W-1:0] rc_q;

  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] cnt;

  logic              rd_hit;
  logic [CELL_W-1:0] rd_data;

  logic              wr_en_q;
  logic [ADDR_W-1:0] wr_addr_q;
  logic [CELL_W-1:0] wr_data_q;
  logic              wr_from_rd_q;

  // Combinational command decode
  logic [ROW_W:0]    row_inc;
  logic [COL_W:0]    col_inc;
  logic [COL_W:0]    tab_col;
  logic [ADDR_W-1:0] lin;
  logic              row_adv;
  logic              exec_scroll;
  logic [ROW_W-1:0]  row_put;
  logic [COL_W-1:0]  col_put;
  logic              bs_move;
  logic              rd_in_range;
  logic [CELL_W-1:0] blank;
  logic              wr_req;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              wr_from_rd;
  logic              rd_req;
  logic [ADDR_W-1:0] rd_addr;

  assign blank = {attr, tcce_pkg::CHAR_BLANK};

  always_comb begin
    row_inc     = {1'b0, row} + (ROW_W+1)'(1);
    col_inc     = {1'b0, col} + (COL_W+1)'(1);
    tab_col     = ({1'b0, col} + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
    lin         = tcce_pkg::cell_addr(ADDR_W'(row), ADDR_W'(col));
    row_adv     = 1'b0;
    col_put     = col;
    if (ch_q == tcce_pkg::CHAR_NL) begin
      col_put = '0;
      row_adv = 1'b1;
    end else if (ch_q == tcce_pkg::CHAR_TAB) begin
      if (tab_col >= (COL_W+1)'(tcce_pkg::COLS)) begin
        col_put = '0;
        row_adv = 1'b1;
      end else begin
        col_put = tab_col[COL_W-1:0];
      end
    end else begin
      if (col_inc >= (COL_W+1)'(tcce_pkg::COLS)) begin
        col_put = '0;
        row_adv = 1'b1;
      end else begin
        col_put = col_inc[COL_W-1:0];
      end
    end
    exec_scroll = row_adv && (row_inc >= (ROW_W+1)'(tcce_pkg::ROWS));
    if (!row_adv) begin
      row_put = row;
    end else if (exec_scroll) begin
      row_put = ROW_W'(tcce_pkg::ROWS - 1);
    end else begin
      row_put = row_inc[ROW_W-1:0];
    end
    bs_move     = (col != '0) || (row != '0);
    rd_in_range = (32'(rr_q) < tcce_pkg::ROWS) && (32'(rc_q) < tcce_pkg::COLS);

    wr_req     = 1'b0;
    wr_addr    = cnt;
    wr_data    = blank;
    wr_from_rd = 1'b0;
    rd_req     = 1'b0;
    rd_addr    = tcce_pkg::cell_addr(ADDR_W'(rr_q), ADDR_W'(rc_q));

    if (cmd.exec) begin
      case (f_q)
        tcce_pkg::FUNC_PUT: begin
          if (ch_q != tcce_pkg::CHAR_NL && ch_q != tcce_pkg::CHAR_TAB) begin
            wr_req  = 1'b1;
            wr_addr = lin;
            wr_data = {attr, ch_q};
          end
        end
        tcce_pkg::FUNC_BACK: begin
          // Stepping back across a row end still lands on linear position minus one
          wr_req  = bs_move;
          wr_addr = lin - ADDR_W'(1);
        end
        tcce_pkg::FUNC_READ: begin
          rd_req = rd_in_range;
        end
        default: begin
        end
      endcase
    end
    if (cmd.scroll_step) begin
      rd_req     = 1'b1;
      rd_addr    = cnt + ADDR_W'(tcce_pkg::COLS);
      wr_req     = 1'b1;
      wr_addr    = cnt;
      wr_from_rd = 1'b1;
    end
    if (cmd.fill_step) begin
      wr_req  = 1'b1;
      wr_addr = cnt;
      wr_data = cmd.fill_reset ? {tcce_pkg::ATTR_RESET, tcce_pkg::CHAR_BLANK} : blank;
    end
  end

  assign sts.func         = f_q;
  assign sts.exec_scroll  = exec_scroll;
  assign sts.cnt_copy_end = (cnt == ADDR_W'(tcce_pkg::CELLS - tcce_pkg::COLS - 1));
  assign sts.cnt_end      = (cnt == ADDR_W'(tcce_pkg::CELLS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tcce_pkg::ATTR_RESET;
    end else if (cfg_wr_en) begin
      attr <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      f_q  <= tcce_pkg::func_t'(func);
      ch_q <= char_code;
      rr_q <= read_row;
      rc_q <= read_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_zero) begin
      cnt <= '0;
    end else if (cmd.cnt_row) begin
      cnt <= ADDR_W'(tcce_pkg::CELLS - tcce_pkg::COLS);
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (cmd.exec) begin
      case (f_q)
        tcce_pkg::FUNC_PUT: begin
          row <= row_put;
          col <= col_put;
        end
        tcce_pkg::FUNC_BACK: begin
          if (col != '0) begin
            col <= col - COL_W'(1);
          end else if (row != '0) begin
            row <= row - ROW_W'(1);
            col <= COL_W'(tcce_pkg::COLS - 1);
          end
        end
        tcce_pkg::FUNC_CLEAR: begin
          row <= '0;
          col <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Write stage: writes are registered and land in the cycle after they are issued, so a scroll copy
  // can take its data from the read register
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_en_q <= 1'b0;
    end else begin
      wr_en_q <= wr_req;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_q    <= wr_addr;
    wr_data_q    <= wr_data;
    wr_from_rd_q <= wr_from_rd;
  end

  always_ff @(posedge clk) begin
    if (wr_en_q) begin
      mem[wr_addr_q] <= wr_from_rd_q ? rd_data : wr_data_q;
    end
    if (rd_req) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_hit <= (f_q == tcce_pkg::FUNC_READ) && rd_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      cursor_row_out <= tcce_pkg::OROW_W'(row);
      cursor_col_out <= tcce_pkg::OCOL_W'(col);
      cursor_linear  <= tcce_pkg::OLIN_W'(lin);
      cell_char      <= rd_hit ? rd_data[tcce_pkg::CHAR_W-1:0] : '0;
      cell_attr      <= rd_hit ? rd_data[CELL_W-1:tcce_pkg::CHAR_W] : '0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/text_console_cursor_engine_top.sv =====
// Text console cursor engine: 80x25 cell store with cursor, put/backspace/clear/read.
// Put, newline, tab, backspace and read pass from accept through execute to a finish state
// that raises out_valid; a put that passes the last row adds a scroll (one cell copied or
// blanked per cycle through the single store port), and a clear adds a blanking sweep.
// One item at a time: a new item is taken only after the last result is loaded.
// Reset: synchronous; a pass over the whole store blanks it (0x07 attribute) with in_stall high.
`default_nettype none

module text_console_cursor_engine_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration: text attribute
  input  wire logic                        cfg_wr_en,
  input  wire logic [tcce_pkg::ATTR_W-1:0] cfg_wr_data,
  // command items
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [tcce_pkg::FUNC_W-1:0] func,
  input  wire logic [tcce_pkg::CHAR_W-1:0] char_code,
  input  wire logic [tcce_pkg::RROW_W-1:0] read_row,
  input  wire logic [tcce_pkg::RCOL_W-1:0] read_col,
  // result items
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [tcce_pkg::OROW_W-1:0]      cursor_row_out,
  output logic [tcce_pkg::OCOL_W-1:0]      cursor_col_out,
  output logic [tcce_pkg::OLIN_W-1:0]      cursor_linear,
  output logic [tcce_pkg::CHAR_W-1:0]      cell_char,
  output logic [tcce_pkg::ATTR_W-1:0]      cell_attr
);

  tcce_pkg::cmd_t cmd;
  tcce_pkg::sts_t sts;

  // Sequencer: owns the handshake, the state and the result-valid flag
  tcce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: cell store, cursor, attribute and result registers
  tcce_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .func           (func),
    .char_code      (char_code),
    .read_row       (read_row),
    .read_col       (read_col),
    .cursor_row_out (cursor_row_out),
    .cursor_col_out (cursor_col_out),
    .cursor_linear  (cursor_linear),
    .cell_char      (cell_char),
    .cell_attr      (cell_attr)
  );

  // An accepted item is executed in the very next cycle
  a_exec_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> cmd.exec)
    else $error("accepted item not executed");

  // Never overwrite a result that is still waiting
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  // Only one source claims the store port in a cycle
  a_one_store_user: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.exec, cmd.scroll_step, cmd.fill_step}))
    else $error("store port claimed twice");

  // Linear position agrees with row and column on every shown result
  a_linear_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor_linear == tcce_pkg::OLIN_W'(tcce_pkg::cell_addr(
      tcce_pkg::ADDR_W'(cursor_row_out), tcce_pkg::ADDR_W'(cursor_col_out))))
    else $error("cursor_linear mismatch");

  // The reset blanking pass never runs while items are taken
  a_init_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.fill_step && cmd.fill_reset) |-> in_stall)
    else $error("item taken during reset blanking");

endmodule

`default_nettype wire

// ===== sim/tb_text_console_cursor_engine_top.sv =====
// Self-checking testbench for text_console_cursor_engine_top: directed table, then random items.
// Depends on tcce_pkg (sv/tcce_pkg.sv) and the engine RTL; keeps its own console shadow.
`timescale 1ns / 100ps

module tb_text_console_cursor_engine_top;
  import tcce_pkg::*;

  // Run limit: ~300 items, each worst case a full store sweep plus long stalls, many times over
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int RAND_PER_PHASE = 83;

  typedef struct packed {
    logic [OROW_W-1:0] row;
    logic [OCOL_W-1:0] col;
    logic [OLIN_W-1:0] lin;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
  } console_result_t;

  typedef struct packed {
    func_t             f;
    logic [CHAR_W-1:0] ch;
    logic [RROW_W-1:0] rr;
    logic [RCOL_W-1:0] rc;
    logic [4:0]        reps;
    logic              typed;
    console_result_t   want;
  } probe_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [ATTR_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] func = '0;
  logic [CHAR_W-1:0] char_code = '0;
  logic [RROW_W-1:0] read_row = '0;
  logic [RCOL_W-1:0] read_col = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OROW_W-1:0] cursor_row_out;
  logic [OCOL_W-1:0] cursor_col_out;
  logic [OLIN_W-1:0] cursor_linear;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;

  // Console shadow: cell store, cursor and the current text attribute
  logic [CELL_W-1:0] con_cells [0:CELLS-1];
  int                con_row;
  int                con_col;
  logic [ATTR_W-1:0] con_attr;

  console_result_t   results_due [$];
  int                mismatch_count = 0;
  int                cycle_count = 0;
  int                snd_idle_pct = 0;
  int                rcv_idle_pct = 0;

  // Directed table, run with the reset attribute 0x07. Rows with typed = 1 carry the
  // expected result by hand; the rest are checked against the shadow.
  probe_row_t dir_rows [0:28] = '{
    // fresh store after the reset sweep, and a fully out-of-range read
    '{FUNC_READ,  8'h00, 5'd0,  7'd0,   5'd1,  1'b1, '{5'd0,  7'd0,  11'd0,    8'h20, 8'h07}},
    '{FUNC_READ,  8'hFF, 5'd31, 7'd127, 5'd1,  1'b1, '{5'd0,  7'd0,  11'd0,    8'h00, 8'h00}},
    // backspace at the origin changes nothing
    '{FUNC_BACK,  8'h00, 5'd0,  7'd0,   5'd1,  1'b1, '{5'd0,  7'd0,  11'd0,    8'h00, 8'h00}},
    '{FUNC_PUT,   8'h41, 5'd0,  7'd0,   5'd1,  1'b1, '{5'd0,  7'd1,  11'd1,    8'h00, 8'h00}},
    '{FUNC_READ,  8'h00, 5'd0,  7'd0,   5'd1,  1'b1, '{5'd0,  7'd1,  11'd1,    8'h41, 8'h07}},
    '{FUNC_PUT,   8'hFF, 5'd0,  7'd0,   5'd1,  1'b1, '{5'd0,  7'd2,  11'd2,    8'h00, 8'h00}},
    '{FUNC_PUT,   8'h00, 5'd0,  7'd0,   5'd1,  1'b1, '{5'd0,  7'd3,  11'd3,    8'h00, 8'h00}},
    // tab from an odd column, then from a multiple of four
    '{FUNC_PUT,   CHAR_TAB, 5'd0, 7'd0, 5'd1,  1'b1, '{5'd0,  7'd4,  11'd4,    8'h00, 8'h00}},
    '{FUNC_PUT,   CHAR_TAB, 5'd0, 7'd0, 5'd1,  1'b1, '{5'd0,  7'd8,  11'd8,    8'h00, 8'h00}},
    '{FUNC_READ,  8'h00, 5'd0,  7'd1,   5'd1,  1'b1, '{5'd0,  7'd8,  11'd8,    8'hFF, 8'h07}},
    '{FUNC_PUT,   CHAR_NL,  5'd0, 7'd0, 5'd1,  1'b1, '{5'd1,  7'd0,  11'd80,   8'h00, 8'h00}},
    // backspace at column zero climbs to the end of the row above and blanks it
    '{FUNC_BACK,  8'h00, 5'd0,  7'd0,   5'd1,  1'b1, '{5'd0,  7'd79, 11'd79,   8'h00, 8'h00}},
    '{FUNC_READ,  8'h00, 5'd0,  7'd79,  5'd1,  1'b1, '{5'd0,  7'd79, 11'd79,   8'h20, 8'h07}},
    // character in the last column wraps the cursor to the next row
    '{FUNC_PUT,   8'h5A, 5'd0,  7'd0,   5'd1,  1'b1, '{5'd1,  7'd0,  11'd80,   8'h00, 8'h00}},
    '{FUNC_READ,  8'h00, 5'd0,  7'd79,  5'd1,  1'b1, '{5'd1,  7'd0,  11'd80,   8'h5A, 8'h07}},
    '{FUNC_READ,  8'h00, 5'd24, 7'd79,  5'd1,  1'b1, '{5'd1,  7'd0,  11'd80,   8'h20, 8'h07}},
    '{FUNC_READ,  8'h00, 5'd25, 7'd0,   5'd1,  1'b1, '{5'd1,  7'd0,  11'd80,   8'h00, 8'h00}},
    '{FUNC_READ,  8'h00, 5'd0,  7'd80,  5'd1,  1'b1, '{5'd1,  7'd0,  11'd80,   8'h00, 8'h00}},
    '{FUNC_BACK,  8'h00, 5'd0,  7'd0,   5'd1,  1'b1, '{5'd0,  7'd79, 11'd79,   8'h00, 8'h00}},
    // tab from the last column wraps
    '{FUNC_PUT,   CHAR_TAB, 5'd0, 7'd0, 5'd1,  1'b1, '{5'd1,  7'd0,  11'd80,   8'h00, 8'h00}},
    '{FUNC_PUT,   8'h51, 5'd0,  7'd0,   5'd1,  1'b0, '0},
    // walk down to the last row, then pass it to force a scroll
    '{FUNC_PUT,   CHAR_NL,  5'd0, 7'd0, 5'd23, 1'b0, '0},
    '{FUNC_PUT,   8'h52, 5'd0,  7'd0,   5'd1,  1'b1, '{5'd24, 7'd1,  11'd1921, 8'h00, 8'h00}},
    '{FUNC_PUT,   CHAR_NL,  5'd0, 7'd0, 5'd1,  1'b1, '{5'd24, 7'd0,  11'd1920, 8'h00, 8'h00}},
    '{FUNC_READ,  8'h00, 5'd23, 7'd0,   5'd1,  1'b1, '{5'd24, 7'd0,  11'd1920, 8'h52, 8'h07}},
    '{FUNC_READ,  8'h00, 5'd0,  7'd0,   5'd1,  1'b1, '{5'd24, 7'd0,  11'd1920, 8'h51, 8'h07}},
    '{FUNC_READ,  8'h00, 5'd24, 7'd0,   5'd1,  1'b1, '{5'd24, 7'd0,  11'd1920, 8'h20, 8'h07}},
    // clear homes the cursor and blanks the whole store
    '{FUNC_CLEAR, 8'h00, 5'd0,  7'd0,   5'd1,  1'b1, '{5'd0,  7'd0,  11'd0,    8'h00, 8'h00}},
    '{FUNC_READ,  8'h00, 5'd24, 7'd79,  5'd1,  1'b1, '{5'd0,  7'd0,  11'd0,    8'h20, 8'h07}}
  };

  text_console_cursor_engine_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .char_code      (char_code),
    .read_row       (read_row),
    .read_col       (read_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cursor_row_out (cursor_row_out),
    .cursor_col_out (cursor_col_out),
    .cursor_linear  (cursor_linear),
    .cell_char      (cell_char),
    .cell_attr      (cell_attr)
  );

  always #5 clk = ~clk;

  // Apply one command to the console shadow and return the result it should produce.
  function automatic console_result_t console_apply(func_t f, logic [CHAR_W-1:0] ch,
                                                    logic [RROW_W-1:0] rr,
                                                    logic [RCOL_W-1:0] rc);
    console_result_t res;
    logic [CELL_W-1:0] cell_word;
    int idx;
    res = '0;
    case (f)
      FUNC_PUT: begin
        if (ch == CHAR_NL) begin
          con_col = 0;
          con_row++;
        end else if (ch == CHAR_TAB) begin
          con_col = (con_col + 4) & ~3;
          if (con_col >= COLS) begin
            con_col = 0;
            con_row++;
          end
        end else begin
          con_cells[con_row * COLS + con_col] = {con_attr, ch};
          con_col++;
          if (con_col >= COLS) begin
            con_col = 0;
            con_row++;
          end
        end
        // past the last row: shift every row up one, blank the bottom one
        if (con_row >= ROWS) begin
          for (idx = 0; idx < CELLS - COLS; idx++)
            con_cells[idx] = con_cells[idx + COLS];
          for (idx = CELLS - COLS; idx < CELLS; idx++)
            con_cells[idx] = {con_attr, CHAR_BLANK};
          con_row = ROWS - 1;
        end
      end
      FUNC_BACK: begin
        if (con_col > 0 || con_row > 0) begin
          if (con_col > 0) begin
            con_col--;
          end else begin
            con_row--;
            con_col = COLS - 1;
          end
          con_cells[con_row * COLS + con_col] = {con_attr, CHAR_BLANK};
        end
      end
      FUNC_CLEAR: begin
        for (idx = 0; idx < CELLS; idx++)
          con_cells[idx] = {con_attr, CHAR_BLANK};
        con_row = 0;
        con_col = 0;
      end
      default: begin
        if (int'(rr) < ROWS && int'(rc) < COLS) begin
          cell_word = con_cells[int'(rr) * COLS + int'(rc)];
          res.ch = cell_word[CHAR_W-1:0];
          res.attr = cell_word[CELL_W-1:CHAR_W];
        end
      end
    endcase
    res.row = OROW_W'(con_row);
    res.col = OCOL_W'(con_col);
    res.lin = OLIN_W'(con_row * COLS + con_col);
    return res;
  endfunction

  // Offer one command; after the accepting edge, queue what it should return.
  task automatic issue_cmd(func_t f, logic [CHAR_W-1:0] ch, logic [RROW_W-1:0] rr,
                           logic [RCOL_W-1:0] rc, logic typed, console_result_t want);
    console_result_t pred;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    char_code <= ch;
    read_row  <= rr;
    read_col  <= rc;
    do @(posedge clk); while (in_stall);
    pred = console_apply(f, ch, rr, rc);
    results_due.push_back(typed ? want : pred);
  endtask

  // Random command: mostly text with line breaks, some backspaces and reads, rare clears.
  task automatic issue_random_cmd();
    int pick;
    func_t f;
    logic [CHAR_W-1:0] ch;
    logic [RROW_W-1:0] rr;
    logic [RCOL_W-1:0] rc;
    pick = $urandom_range(99);
    ch = CHAR_W'($urandom_range(255));
    rr = RROW_W'($urandom_range(31));
    rc = RCOL_W'($urandom_range(127));
    if (pick < 1) begin
      f = FUNC_CLEAR;
    end else if (pick < 13) begin
      f = FUNC_BACK;
    end else if (pick < 35) begin
      f = FUNC_READ;
      // keep most reads inside the screen, half of them on the cursor row
      if ($urandom_range(9) < 8) begin
        rr = $urandom_range(1) ? RROW_W'(con_row) : RROW_W'($urandom_range(ROWS - 1));
        rc = RCOL_W'($urandom_range(COLS - 1));
      end
    end else begin
      f = FUNC_PUT;
      pick = $urandom_range(99);
      if (pick < 25) ch = CHAR_NL;
      else if (pick < 33) ch = CHAR_TAB;
    end
    issue_cmd(f, ch, rr, rc, 1'b0, '0);
  endtask

  // Drain, let the engine settle, then load a new text attribute.
  task automatic set_attribute(logic [ATTR_W-1:0] value);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    con_attr = value;
  endtask

  // Result side: check each accepted item against the oldest expectation, stall at random.
  always @(posedge clk) begin : result_check
    console_result_t got;
    console_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {cursor_row_out, cursor_col_out, cursor_linear, cell_char, cell_attr};
        if (results_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result row %0d col %0d lin %0d char %02h attr %02h",
                   $time, got.row, got.col, got.lin, got.ch, got.attr);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: mismatch expected row %0d col %0d lin %0d char %02h attr %02h",
                     $time, want.row, want.col, want.lin, want.ch, want.attr);
            $display("%0t:          actual   row %0d col %0d lin %0d char %02h attr %02h",
                     $time, got.row, got.col, got.lin, got.ch, got.attr);
          end
        end
      end
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int i;
    // shadow starts as the post-reset store: blanks with attribute 0x07, cursor home
    for (i = 0; i < CELLS; i++)
      con_cells[i] = {ATTR_RESET, CHAR_BLANK};
    con_row  = 0;
    con_col  = 0;
    con_attr = ATTR_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table; the engine's own clearing pass holds off the first item
    snd_idle_pct = 28;
    rcv_idle_pct = 88;
    foreach (dir_rows[r])
      repeat (dir_rows[r].reps)
        issue_cmd(dir_rows[r].f, dir_rows[r].ch, dir_rows[r].rr, dir_rows[r].rc,
                  dir_rows[r].typed, dir_rows[r].want);

    // sender sparse-ish, receiver mostly stalled; all-ones attribute
    set_attribute(8'hFF);
    repeat (RAND_PER_PHASE) issue_random_cmd();

    // sender mostly idle, receiver eager; all-zeros attribute
    set_attribute(8'h00);
    snd_idle_pct = 88;
    rcv_idle_pct = 28;
    repeat (RAND_PER_PHASE) issue_random_cmd();

    // back to back on both sides with an arbitrary attribute
    set_attribute(ATTR_W'($urandom_range(1, 254)));
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    repeat (RAND_PER_PHASE) issue_random_cmd();

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
